[src/lir_pkg.sv]
`timescale 1ns / 1ps

package lir_pkg;

   // Sample and position formats.
   localparam int SAMPLE_BITS   = 16;
   localparam int FRACTION_BITS = 16;
   localparam int STEP_BITS     = 21;
   // A position stays below seventeen whole samples, so five integer bits suffice.
   localparam int POS_BITS      = FRACTION_BITS + 5;

   localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1) << FRACTION_BITS;
   localparam logic [POS_BITS-1:0] POS_TWO = POS_BITS'(2) << FRACTION_BITS;

   // Step limits: one sixteenth up to sixteen source samples per output.
   localparam logic [STEP_BITS-1:0] STEP_MIN   = STEP_BITS'(1) << (FRACTION_BITS - 4);
   localparam logic [STEP_BITS-1:0] STEP_MAX   = STEP_BITS'(1) << (FRACTION_BITS + 4);
   localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1) << FRACTION_BITS;

   // Source of an emitted result.
   typedef enum logic [1:0] {
      EMIT_INTERP,
      EMIT_TAIL,
      EMIT_EMPTY
   } emit_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          load_in;
      logic          pos_clear;
      logic          pos_advance;
      logic          pos_wrap;
      logic          prev_commit;
      logic          clip_clear;
      logic          emit;
      emit_kind_type kind;
      logic          final_flag;
   } cmd_type;

   // Position status back to the controller.
   typedef struct packed {
      logic pos_lt_one;
      logic next_ge_one;
      logic next_ge_two;
   } stat_type;

endpackage

[src/lir_datapath.sv]
`timescale 1ns / 1ps

module lir_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [lir_pkg::STEP_BITS-1:0]         csr_wr_data,
   input  logic signed [lir_pkg::SAMPLE_BITS-1:0] sample_in,
   input  lir_pkg::cmd_type                      cmd,
   output lir_pkg::stat_type                     stat,
   output logic signed [lir_pkg::SAMPLE_BITS-1:0] sample_out,
   output logic                                  has_sample,
   output logic                                  final_result
);

   localparam int PROD_BITS = lir_pkg::SAMPLE_BITS + lir_pkg::FRACTION_BITS + 2;
   localparam int Q_BITS    = PROD_BITS - lir_pkg::FRACTION_BITS;

   logic [lir_pkg::STEP_BITS-1:0]          step_ff;
   logic [lir_pkg::STEP_BITS-1:0]          step_clamped;
   logic [lir_pkg::POS_BITS-1:0]           pos_ff, pos_in, next_pos;
   logic signed [lir_pkg::SAMPLE_BITS-1:0] prev_ff, prev_in, cur_ff, cur_in;
   logic signed [lir_pkg::SAMPLE_BITS-1:0] out_ff, out_in;
   logic                                   has_ff, has_in, fin_ff, fin_in;
   logic signed [lir_pkg::SAMPLE_BITS:0]   diff;
   logic signed [lir_pkg::FRACTION_BITS:0] frac;
   logic signed [PROD_BITS-1:0]            prod;
   logic signed [Q_BITS-1:0]               quot, interp_sum;

   // Clamp the programmed step into its legal range.
   always_comb begin
      step_clamped = step_ff;
      if (step_ff < lir_pkg::STEP_MIN) begin
         step_clamped = lir_pkg::STEP_MIN;
      end else if (step_ff > lir_pkg::STEP_MAX) begin
         step_clamped = lir_pkg::STEP_MAX;
      end
   end

   assign next_pos = pos_ff + lir_pkg::POS_BITS'(step_clamped);

   assign stat.pos_lt_one  = pos_ff < lir_pkg::POS_ONE;
   assign stat.next_ge_one = next_pos >= lir_pkg::POS_ONE;
   assign stat.next_ge_two = next_pos >= lir_pkg::POS_TWO;

   // Interpolation: prev + floor((cur - prev) * frac / ONE).
   always_comb begin
      diff = {cur_ff[lir_pkg::SAMPLE_BITS-1], cur_ff}
           - {prev_ff[lir_pkg::SAMPLE_BITS-1], prev_ff};
      frac = {1'b0, pos_ff[lir_pkg::FRACTION_BITS-1:0]};
      prod = PROD_BITS'(diff) * PROD_BITS'(frac);
      quot = prod[PROD_BITS-1:lir_pkg::FRACTION_BITS];
      interp_sum = Q_BITS'(prev_ff) + quot;
   end

   // Next values of the position, sample history and result register.
   always_comb begin
      pos_in  = pos_ff;
      prev_in = prev_ff;
      cur_in  = cur_ff;
      out_in  = out_ff;
      has_in  = has_ff;
      fin_in  = fin_ff;

      if (cmd.load_in) begin
         cur_in = sample_in;
      end
      if (cmd.prev_commit) begin
         prev_in = cmd.load_in ? sample_in : cur_ff;
      end

      if (cmd.pos_clear || cmd.clip_clear) begin
         pos_in = '0;
      end else if (cmd.pos_advance) begin
         pos_in = next_pos;
      end else if (cmd.pos_wrap) begin
         pos_in = pos_ff - lir_pkg::POS_ONE;
      end
      if (cmd.clip_clear) begin
         prev_in = '0;
      end

      if (cmd.emit) begin
         fin_in = cmd.final_flag;
         case (cmd.kind)
            lir_pkg::EMIT_INTERP: begin
               out_in = interp_sum[lir_pkg::SAMPLE_BITS-1:0];
               has_in = 1'b1;
            end
            lir_pkg::EMIT_TAIL: begin
               out_in = cur_ff;
               has_in = 1'b1;
            end
            default: begin
               out_in = '0;
               has_in = 1'b0;
            end
         endcase
      end
   end

   // Step register holds its reset value until software writes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= lir_pkg::STEP_RESET;
         pos_ff  <= '0;
         prev_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            step_ff <= csr_wr_data;
         end
         pos_ff  <= pos_in;
         prev_ff <= prev_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
      has_ff <= has_in;
      fin_ff <= fin_in;
   end

   assign sample_out   = out_ff;
   assign has_sample   = has_ff;
   assign final_result = fin_ff;

endmodule

[src/lir_ctrl.sv]
`timescale 1ns / 1ps

module lir_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  lir_pkg::stat_type stat,
   output lir_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INTERP,
      ST_TAIL
   } state_type;

   state_type state_ff, state_in;
   logic      have_prev_ff, have_prev_in;
   logic      eos_ff, eos_in;
   logic      emitted_ff, emitted_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      load_ok;

   // The result register can take a new item when empty or being drained.
   assign load_ok = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd          = '0;
      cmd.kind     = lir_pkg::EMIT_INTERP;
      state_in     = state_ff;
      have_prev_in = have_prev_ff;
      eos_in       = eos_ff;
      emitted_in   = emitted_ff;
      req_tready   = 1'b0;

      case (state_ff)
         // Wait for an input item; nothing is taken while reset is held.
         ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid) begin
               cmd.load_in  = 1'b1;
               eos_in       = req_tlast;
               emitted_in   = 1'b0;
               have_prev_in = !req_tlast;
               if (have_prev_ff) begin
                  state_in = ST_INTERP;
               end else begin
                  cmd.pos_clear = 1'b1;
                  if (req_tlast) begin
                     state_in = ST_TAIL;
                  end else begin
                     cmd.prev_commit = 1'b1;
                  end
               end
            end
         end

         // Emit the positions between the previous and the current sample.
         ST_INTERP: begin
            if (stat.pos_lt_one) begin
               if (load_ok) begin
                  cmd.emit        = 1'b1;
                  cmd.kind        = lir_pkg::EMIT_INTERP;
                  cmd.pos_advance = 1'b1;
                  // Final only if the clip ends and no tail position remains.
                  cmd.final_flag  = eos_ff && stat.next_ge_two;
                  emitted_in      = 1'b1;
               end
            end else begin
               cmd.pos_wrap    = 1'b1;
               cmd.prev_commit = 1'b1;
               state_in        = eos_ff ? ST_TAIL : ST_IDLE;
            end
         end

         // Clip end: repeat the last sample, or send an empty marker.
         ST_TAIL: begin
            if (stat.pos_lt_one) begin
               if (load_ok) begin
                  cmd.emit        = 1'b1;
                  cmd.kind        = lir_pkg::EMIT_TAIL;
                  cmd.pos_advance = 1'b1;
                  cmd.final_flag  = stat.next_ge_one;
                  emitted_in      = 1'b1;
               end
            end else if (emitted_ff) begin
               cmd.clip_clear = 1'b1;
               have_prev_in   = 1'b0;
               state_in       = ST_IDLE;
            end else if (load_ok) begin
               cmd.emit       = 1'b1;
               cmd.kind       = lir_pkg::EMIT_EMPTY;
               cmd.final_flag = 1'b1;
               cmd.clip_clear = 1'b1;
               have_prev_in   = 1'b0;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Result valid rises on a load and falls once the item is taken.
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         eos_ff       <= 1'b0;
         emitted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         eos_ff       <= eos_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[src/linear_interp_resampler.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Ports                                  | Payload
// ---------+-----------+----------------------------------------+--------------------------
// req      | in        | req_tvalid/tready, tdata, tlast        | sample_in, end_of_stream
// rsp      | out       | rsp_tvalid/tready, tdata, tuser, tlast | sample_out, has_sample,
//          |           |                                        | final_result
// csr      | in        | csr_wr_en, csr_wr_data                 | source_step
//
// An input item is taken in the idle state; the controller then emits its results, one
// per cycle while the sink is ready, and wraps the position before it takes the next
// item. At a clip end the tail state follows to finish the clip.
// Reset is synchronous; it clears the clip state and sets the step to one.
// A stalled sink holds the result register and stops the controller emitting results.

module linear_interp_resampler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,   // [15:0] sample_in
   input  logic                             req_tlast,   // end_of_stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,   // [15:0] sample_out
   output logic                             rsp_tuser,   // [0] has_sample
   output logic                             rsp_tlast,   // final_result
   input  logic                             csr_wr_en,
   input  logic [lir_pkg::STEP_BITS-1:0]    csr_wr_data  // source_step
);

   lir_pkg::cmd_type                       cmd;
   lir_pkg::stat_type                      stat;
   logic signed [lir_pkg::SAMPLE_BITS-1:0] sample_out;

   lir_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lir_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .sample_in    (req_tdata),
      .cmd          (cmd),
      .stat         (stat),
      .sample_out   (sample_out),
      .has_sample   (rsp_tuser),
      .final_result (rsp_tlast)
   );

   assign rsp_tdata = sample_out;

endmodule

[tb/resampler_checker.sv]
`timescale 1ns / 1ps

// Watches both streams of the resampler, predicts the result items from
// each accepted input item, and compares every result item in order.
module resampler_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [15:0]                   req_tdata,
   input  logic                          req_tlast,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [15:0]                   rsp_tdata,
   input  logic                          rsp_tuser,
   input  logic                          rsp_tlast,
   input  logic                          csr_wr_en,
   input  logic [lir_pkg::STEP_BITS-1:0] csr_wr_data,
   output int                            fail_count,
   output int                            expected_count
);

   localparam int REPORT_LIMIT = 200;
   localparam int RESULT_CAP   = 32;

   typedef struct packed {
      logic [15:0] sample;
      logic        has_sample;
      logic        final_flag;
   } result_type;

   result_type                    expected_outputs[$];
   logic [lir_pkg::STEP_BITS-1:0] step_reg;
   logic signed [15:0]            last_sample;
   logic                          last_valid;
   logic [31:0]                   out_position;
   int                            report_count;

   // Linear blend of two samples, rounded toward minus infinity.
   function automatic logic [15:0] blend(input logic signed [15:0] a,
                                         input logic signed [15:0] b,
                                         input logic [31:0] frac);
      longint diff;
      longint prod;
      diff = longint'(b) - longint'(a);
      prod = diff * longint'(frac);
      return 16'(longint'(a) + (prod >>> lir_pkg::FRACTION_BITS));
   endfunction

   // Queue every result item that one input item causes and advance the clip state.
   task automatic interpolate_input(input logic signed [15:0] cur, input logic eos);
      logic [31:0] step;
      int          n;
      result_type  r;
      step = 32'(step_reg);
      if (step < 32'(lir_pkg::STEP_MIN)) step = 32'(lir_pkg::STEP_MIN);
      if (step > 32'(lir_pkg::STEP_MAX)) step = 32'(lir_pkg::STEP_MAX);
      n = 0;
      if (last_valid) begin
         while (out_position < 32'(lir_pkg::POS_ONE) && n < RESULT_CAP) begin
            r = '{blend(last_sample, cur, out_position), 1'b1, 1'b0};
            expected_outputs.push_back(r);
            n++;
            out_position += step;
         end
         out_position -= 32'(lir_pkg::POS_ONE);
      end else begin
         out_position = 32'd0;
      end
      last_sample = cur;
      last_valid  = 1'b1;

      // At the clip end the rest of the positions repeat the last sample.
      if (eos) begin
         while (out_position < 32'(lir_pkg::POS_ONE) && n < RESULT_CAP) begin
            r = '{cur, 1'b1, 1'b0};
            expected_outputs.push_back(r);
            n++;
            out_position += step;
         end
         if (n == 0) begin
            r = '{16'd0, 1'b0, 1'b1};
            expected_outputs.push_back(r);
         end else begin
            r = expected_outputs.pop_back();
            r.final_flag = 1'b1;
            expected_outputs.push_back(r);
         end
         last_sample  = 16'sd0;
         last_valid   = 1'b0;
         out_position = 32'd0;
      end
   endtask

   // Sample both streams and the register port at each rising edge.
   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      if (reset) begin
         expected_outputs.delete();
         step_reg     = lir_pkg::STEP_RESET;
         last_sample  = 16'sd0;
         last_valid   = 1'b0;
         out_position = 32'd0;
         fail_count   = 0;
         report_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            interpolate_input(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, rsp_tuser, rsp_tlast};
            if (expected_outputs.size() == 0) begin
               fail_count++;
               if (report_count < REPORT_LIMIT) begin
                  $display("%0t: unexpected item: expected none, got sample %h has %b final %b",
                           $time, got.sample, got.has_sample, got.final_flag);
               end
               report_count++;
            end else begin
               want = expected_outputs.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (report_count < REPORT_LIMIT) begin
                     $display("%0t: mismatch: expected %h/%b/%b, got %h/%b/%b",
                              $time, want.sample, want.has_sample, want.final_flag,
                              got.sample, got.has_sample, got.final_flag);
                  end
                  report_count++;
               end
            end
         end
         if (csr_wr_en) begin
            step_reg = csr_wr_data;
         end
      end
      expected_count <= expected_outputs.size();
   end

endmodule

[tb/linear_interp_resampler_tb.sv]
`timescale 1ns / 1ps

module linear_interp_resampler_tb;

   localparam int PHASE_ITEMS = 60;
   localparam int PHASES      = 8;
   localparam int SETTLE      = 40;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [15:0]                   req_tdata;
   logic                          req_tlast;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [15:0]                   rsp_tdata;
   logic                          rsp_tuser;
   logic                          rsp_tlast;
   logic                          csr_wr_en;
   logic [lir_pkg::STEP_BITS-1:0] csr_wr_data;
   logic                          steady;
   int                            fail_count;
   int                            expected_count;

   linear_interp_resampler dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   resampler_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .expected_count (expected_count)
   );

   // An 8 ns clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The sink stalls at random unless the steady stretch is on.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= steady ? 1'b1 : ($urandom_range(99) >= 38);
      end
   end

   // Offer one input item, with random idle cycles ahead of it.
   task automatic send_item(input logic [15:0] value, input logic eos);
      while (!steady && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Wait until every predicted item has arrived and the block has gone quiet.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write the step register; the block is idle here.
   task automatic program_step(input logic [lir_pkg::STEP_BITS-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Directed cases first, then random clips under a range of steps.
   initial begin : stimulus
      logic [lir_pkg::STEP_BITS-1:0] step;
      logic [15:0]                   value;
      req_tvalid  <= 1'b0;
      req_tdata   <= 16'd0;
      req_tlast   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      steady = 1'b0;
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Unit step: sample extremes and a clip of one sample.
      program_step(lir_pkg::STEP_RESET);
      send_item(16'h7FFF, 1'b0);
      send_item(16'h8000, 1'b0);
      send_item(16'h0000, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'h7FFF, 1'b1);
      send_item(16'h8000, 1'b1);
      drain();

      // Largest step: the clip ends with no position left, then a one-sample clip.
      program_step(lir_pkg::STEP_MAX);
      send_item(16'h1234, 1'b0);
      send_item(16'h8000, 1'b0);
      send_item(16'h7FFF, 1'b1);
      send_item(16'h7FFF, 1'b1);
      drain();

      // Smallest step: full-scale swings with sixteen items per input item.
      program_step(lir_pkg::STEP_MIN);
      send_item(16'h8000, 1'b0);
      send_item(16'h7FFF, 1'b0);
      send_item(16'h8000, 1'b0);
      send_item(16'h0001, 1'b1);
      drain();

      // Steps outside the range are clamped.
      program_step({lir_pkg::STEP_BITS{1'b1}});
      send_item(16'h0100, 1'b0);
      send_item(16'hFF00, 1'b0);
      send_item(16'h0000, 1'b1);
      drain();
      program_step('0);
      send_item(16'h7FFF, 1'b0);
      send_item(16'h8000, 1'b1);
      drain();

      // A fractional step of one and a half.
      program_step(lir_pkg::STEP_BITS'(98304));
      send_item(16'h1000, 1'b0);
      send_item(16'h2000, 1'b0);
      send_item(16'h3000, 1'b0);
      send_item(16'h4000, 1'b1);
      drain();

      // Random clips, one step setting per phase.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: step = lir_pkg::STEP_MIN;
            1: step = lir_pkg::STEP_MAX;
            2: step = lir_pkg::STEP_BITS'(4096 + $urandom_range(1048576 - 4096));
            3: step = lir_pkg::STEP_BITS'($urandom_range(4095));
            4: step = lir_pkg::STEP_BITS'(1048577 + $urandom_range(2097151 - 1048577));
            5: step = lir_pkg::STEP_BITS'(4096 + $urandom_range(131072 - 4096));
            6: step = lir_pkg::STEP_BITS'(65536 + $urandom_range(1048576 - 65536));
            default: step = lir_pkg::STEP_BITS'(4096 + $urandom_range(1048576 - 4096));
         endcase
         program_step(step);
         steady = (phase == 2);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            case ($urandom_range(15))
               0: value = 16'h8000;
               1: value = 16'h7FFF;
               2: value = 16'h0000;
               3: value = 16'hFFFF;
               default: value = 16'($urandom);
            endcase
            send_item(value, $urandom_range(9) == 0);
         end
         drain();
         steady = 1'b0;
      end

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(5_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

[filelist.f]
src/lir_pkg.sv
src/lir_datapath.sv
src/lir_ctrl.sv
src/linear_interp_resampler.sv
tb/resampler_checker.sv
tb/linear_interp_resampler_tb.sv
